### src/i2cm_pkg.sv
// Shared types and constants for the I2C master register controller.
// No dependencies.
package i2cm_pkg;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RECV  = 3'd3,
        ACT_STOP  = 3'd4
    } t_action;

    localparam logic       OP_READ   = 1'b0;
    localparam logic       OP_WRITE  = 1'b1;

    localparam logic [4:0] ADDR_CTL  = 5'd0;
    localparam logic [4:0] ADDR_STAT = 5'd4;
    localparam logic [4:0] ADDR_OWN  = 5'd8;
    localparam logic [4:0] ADDR_DATA = 5'd12;

    localparam int CTL_ACKEN = 7;
    localparam int CTL_IRQEN = 5;
    localparam int CTL_PEND  = 4;
    localparam int ST_MODE   = 7;
    localparam int ST_TX     = 6;
    localparam int ST_START  = 5;
    localparam int ST_RXTX   = 4;
    localparam int ST_NACK   = 0;

    localparam logic [7:0] CTL_WR_KEEP = 8'hef;

    typedef struct packed {
        logic       operation;
        logic [4:0] reg_addr;
        logic [7:0] write_value;
        logic       target_ack;
        logic [7:0] target_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        t_action    bus_action;
        logic [7:0] bus_byte;
        logic       bus_read_dir;
        logic       bus_nack_out;
        logic       irq_raise;
    } t_result;

endpackage

### src/i2cm_in_reg.sv
// Input register stage: captures one register access transaction.
// Depends on i2cm_pkg.
module i2cm_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_operation,
    input  logic [4:0]      i_reg_addr,
    input  logic [7:0]      i_write_value,
    input  logic            i_target_ack,
    input  logic [7:0]      i_target_byte,
    input  logic            i_take,
    output logic            o_valid,
    output i2cm_pkg::t_item o_item
);
    import i2cm_pkg::*;

    logic  r_vld, n_vld;
    t_item r_item;
    logic  load;

    assign load    = !r_vld || i_take;
    assign o_stall = !load;
    assign n_vld   = load ? i_valid : r_vld;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= '{operation:   i_operation,
                        reg_addr:    i_reg_addr,
                        write_value: i_write_value,
                        target_ack:  i_target_ack,
                        target_byte: i_target_byte};
        end
    end

endmodule

### src/i2cm_core.sv
// Register file, flags and master engine; one transaction per fire.
// Depends on i2cm_pkg.
module i2cm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  i2cm_pkg::t_item   i_item,
    output i2cm_pkg::t_result o_result
);
    import i2cm_pkg::*;

    logic [7:0] r_ctl, n_ctl;
    logic [7:0] r_stat, n_stat;
    logic [7:0] r_data, n_data;
    logic [6:0] r_own, n_own;
    logic       r_busy, n_busy;
    logic       r_sreq, n_sreq;
    t_result    res;
    logic       run, stop, do_start, ack;

    always_comb begin
        n_ctl    = r_ctl;
        n_stat   = r_stat;
        n_data   = r_data;
        n_own    = r_own;
        n_busy   = r_busy;
        n_sreq   = r_sreq;
        res      = '0;
        run      = 1'b0;
        stop     = 1'b0;
        do_start = 1'b0;
        ack      = 1'b1;

        if (i_item.operation == OP_READ) begin
            unique case (i_item.reg_addr)
                ADDR_CTL:  res.read_data = r_ctl;
                ADDR_STAT: res.read_data = r_stat & ~(8'h01 << ST_START);
                ADDR_OWN:  res.read_data = {1'b0, r_own};
                ADDR_DATA: res.read_data = r_data;
                default:   res.read_data = 8'h00;
            endcase
        end else begin
            unique case (i_item.reg_addr)
                ADDR_CTL: begin
                    n_ctl = (r_ctl | CTL_WR_KEEP) & i_item.write_value;
                    run   = r_busy || !n_ctl[CTL_PEND];
                end
                ADDR_STAT: begin
                    n_stat = {i_item.write_value[7:4], r_stat[3:0]};
                    if (n_stat[ST_START]) begin
                        n_sreq = 1'b1;
                    end
                    run = 1'b1;
                end
                ADDR_OWN: n_own = i_item.write_value[6:0];
                ADDR_DATA: begin
                    n_data = i_item.write_value;
                    n_busy = 1'b1;
                end
                default: ;
            endcase
        end

        if (run && !n_ctl[CTL_PEND] && n_stat[ST_MODE] && n_stat[ST_RXTX]) begin
            stop     = !n_stat[ST_START];
            do_start = n_sreq && n_stat[ST_START];
            if (do_start) begin
                n_busy = 1'b1;
            end
            n_sreq = 1'b0;
            if (n_busy) begin
                if (do_start) begin
                    res.bus_action   = ACT_START;
                    res.bus_byte     = {1'b0, n_data[7:1]};
                    res.bus_read_dir = !n_stat[ST_TX];
                    ack              = i_item.target_ack;
                end else if (stop) begin
                    res.bus_action = ACT_STOP;
                end else if (n_stat[ST_TX]) begin
                    res.bus_action = ACT_SEND;
                    res.bus_byte   = n_data;
                    ack            = i_item.target_ack;
                end else begin
                    res.bus_action   = ACT_RECV;
                    n_data           = i_item.target_byte;
                    res.bus_nack_out = !n_ctl[CTL_ACKEN];
                end

                if (!n_stat[ST_START]) begin
                    n_busy = 1'b0;
                end else begin
                    n_stat[ST_NACK] = !ack;
                    if (!ack) begin
                        n_busy = 1'b0;
                    end
                    n_ctl[CTL_PEND] = 1'b1;
                    res.irq_raise   = n_ctl[CTL_IRQEN];
                end
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_stat <= '0;
            r_data <= '0;
            r_own  <= '0;
            r_busy <= 1'b0;
            r_sreq <= 1'b0;
        end else if (i_fire) begin
            r_ctl  <= n_ctl;
            r_stat <= n_stat;
            r_data <= n_data;
            r_own  <= n_own;
            r_busy <= n_busy;
            r_sreq <= n_sreq;
        end
    end

endmodule

### src/i2c_master_register_controller_unit.sv
// Top level of the I2C master register controller: input register, core, result register.
// Depends on i2cm_pkg, i2cm_in_reg, i2cm_core.
//
//  channel  handshake                  payload
//  in       i_in_valid / o_in_stall    i_operation, i_reg_addr, i_write_value,
//                                      i_target_ack, i_target_byte
//  out      o_out_valid / i_out_stall  o_read_data, o_bus_action, o_bus_byte,
//                                      o_bus_read_dir, o_bus_nack_out, o_irq_raise
//
// Results are registered; one per cycle sustained while i_out_stall is low.
// The core state updates when a transaction moves into the result register.
// Synchronous active-low reset clears valid flags and core state; payload is not reset.
// A stalled result register holds and back-pressures the input register.
module i2c_master_register_controller_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic [4:0] i_reg_addr,
    input  logic [7:0] i_write_value,
    input  logic       i_target_ack,
    input  logic [7:0] i_target_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic [2:0] o_bus_action,
    output logic [7:0] o_bus_byte,
    output logic       o_bus_read_dir,
    output logic       o_bus_nack_out,
    output logic       o_irq_raise
);
    import i2cm_pkg::*;

    logic    item_vld;
    t_item   item;
    t_result res;
    logic    out_free, take;
    logic    r_out_vld, n_out_vld;
    t_result r_res;

    assign out_free  = !r_out_vld || !i_out_stall;
    assign take      = item_vld && out_free;
    assign n_out_vld = take || (r_out_vld && i_out_stall);

    i2cm_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_operation   (i_operation),
        .i_reg_addr    (i_reg_addr),
        .i_write_value (i_write_value),
        .i_target_ack  (i_target_ack),
        .i_target_byte (i_target_byte),
        .i_take        (take),
        .o_valid       (item_vld),
        .o_item        (item)
    );

    i2cm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_item   (item),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_read_data    = r_res.read_data;
    assign o_bus_action   = r_res.bus_action;
    assign o_bus_byte     = r_res.bus_byte;
    assign o_bus_read_dir = r_res.bus_read_dir;
    assign o_bus_nack_out = r_res.bus_nack_out;
    assign o_irq_raise    = r_res.irq_raise;

endmodule

### test/i2c_master_register_controller_unit_test.sv
`timescale 1ns / 100ps
// Testbench for i2c_master_register_controller_unit: register accesses and master transfers,
// checked against a behavioural predictor of the register file and master engine.
// Depends on i2cm_pkg and the controller RTL.
module i2c_master_register_controller_unit_test;
    import i2cm_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       operation = OP_READ;
    logic [4:0] reg_addr = ADDR_CTL;
    logic [7:0] write_value = 8'h00;
    logic       target_ack = 1'b0;
    logic [7:0] target_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic       bus_read_dir;
    logic       bus_nack_out;
    logic       irq_raise;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int accesses_sent = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    t_result access_results_q[$];

    // shadow copy of the controller state
    logic [7:0] control_shadow = '0;
    logic [7:0] status_shadow = '0;
    logic [7:0] data_shadow = '0;
    logic [6:0] own_addr_shadow = '0;
    logic       busy_shadow = 1'b0;
    logic       start_pending = 1'b0;

    i2c_master_register_controller_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_reg_addr     (reg_addr),
        .i_write_value  (write_value),
        .i_target_ack   (target_ack),
        .i_target_byte  (target_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_read_data    (read_data),
        .o_bus_action   (bus_action),
        .o_bus_byte     (bus_byte),
        .o_bus_read_dir (bus_read_dir),
        .o_bus_nack_out (bus_nack_out),
        .o_irq_raise    (irq_raise)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_result predict_access(input t_item it);
        t_result r;
        logic    run;
        logic    halt;
        logic    launch;
        logic    acked;
        r = '0;
        run = 1'b0;
        if (it.operation == OP_READ) begin
            case (it.reg_addr)
                ADDR_CTL:  r.read_data = control_shadow;
                ADDR_STAT: begin
                    r.read_data = status_shadow;
                    r.read_data[ST_START] = 1'b0;
                end
                ADDR_OWN:  r.read_data = {1'b0, own_addr_shadow};
                ADDR_DATA: r.read_data = data_shadow;
                default:   r.read_data = 8'h00;
            endcase
            return r;
        end
        case (it.reg_addr)
            ADDR_CTL: begin
                control_shadow = (control_shadow | CTL_WR_KEEP) & it.write_value;
                run = busy_shadow || !control_shadow[CTL_PEND];
            end
            ADDR_STAT: begin
                status_shadow = {it.write_value[7:4], status_shadow[3:0]};
                if (status_shadow[ST_START]) start_pending = 1'b1;
                run = 1'b1;
            end
            ADDR_OWN:  own_addr_shadow = it.write_value[6:0];
            ADDR_DATA: begin
                data_shadow = it.write_value;
                busy_shadow = 1'b1;
            end
            default: ;
        endcase
        // master engine: runs only when triggered, not pending, and with the mode and rxtx status bits set
        if (run && !control_shadow[CTL_PEND] &&
            status_shadow[ST_MODE] && status_shadow[ST_RXTX]) begin
            halt = !status_shadow[ST_START];
            launch = start_pending && status_shadow[ST_START];
            if (launch) busy_shadow = 1'b1;
            start_pending = 1'b0;
            if (busy_shadow) begin
                acked = 1'b1;
                if (launch) begin
                    r.bus_action = ACT_START;
                    r.bus_byte = {1'b0, data_shadow[7:1]};
                    r.bus_read_dir = !status_shadow[ST_TX];
                    acked = it.target_ack;
                end else if (halt) begin
                    r.bus_action = ACT_STOP;
                end else if (status_shadow[ST_TX]) begin
                    r.bus_action = ACT_SEND;
                    r.bus_byte = data_shadow;
                    acked = it.target_ack;
                end else begin
                    r.bus_action = ACT_RECV;
                    data_shadow = it.target_byte;
                    r.bus_nack_out = !control_shadow[CTL_ACKEN];
                end
                if (halt) begin
                    busy_shadow = 1'b0;
                end else begin
                    status_shadow[ST_NACK] = !acked;
                    if (!acked) busy_shadow = 1'b0;
                    control_shadow[CTL_PEND] = 1'b1;
                    r.irq_raise = control_shadow[CTL_IRQEN];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        if (mismatches < 100)
            $display("mismatch %s at %0t: got %02h, expected %02h", what, $realtime, got, want);
        mismatches++;
    endtask

    task automatic send_access(input logic op, input logic [4:0] addr, input logic [7:0] val,
                               input logic ack, input logic [7:0] rx);
        t_item it;
        it = {op, addr, val, ack, rx};
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        reg_addr <= addr;
        write_value <= val;
        target_ack <= ack;
        target_byte <= rx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        access_results_q.push_back(predict_access(it));
        accesses_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (access_results_q.size() != 0) @(posedge clk);
    endtask

    // register file behaviour, no bus activity
    task automatic test_register_access();
        send_access(OP_READ, ADDR_CTL, 8'h00, 1'b0, 8'h00);
        send_access(OP_READ, ADDR_STAT, 8'hff, 1'b1, 8'hff);
        send_access(OP_READ, ADDR_OWN, 8'h00, 1'b0, 8'h00);
        send_access(OP_READ, ADDR_DATA, 8'h00, 1'b0, 8'h00);
        send_access(OP_READ, 5'd31, 8'h00, 1'b0, 8'h00);
        send_access(OP_WRITE, ADDR_OWN, 8'hff, 1'b1, 8'hff);
        send_access(OP_READ, ADDR_OWN, 8'h00, 1'b0, 8'h00);
        send_access(OP_WRITE, 5'd31, 8'hff, 1'b1, 8'hff);
        send_access(OP_WRITE, 5'd3, 8'hff, 1'b1, 8'hff);
        send_access(OP_WRITE, ADDR_CTL, 8'hff, 1'b1, 8'hff);
        send_access(OP_READ, ADDR_CTL, 8'h00, 1'b0, 8'h00);
        wait_drained();
    endtask

    // start, send, receive and stop, with nack and interrupt cases
    task automatic test_master_transfer();
        send_access(OP_WRITE, ADDR_STAT, 8'h20, 1'b1, 8'h00);
        send_access(OP_READ, ADDR_STAT, 8'h00, 1'b0, 8'h00);
        send_access(OP_WRITE, ADDR_DATA, 8'ha5, 1'b1, 8'h00);
        send_access(OP_WRITE, ADDR_STAT, 8'hb0, 1'b0, 8'h00);
        send_access(OP_READ, ADDR_STAT, 8'h00, 1'b0, 8'h00);
        send_access(OP_WRITE, ADDR_CTL, 8'h00, 1'b1, 8'h00);
        send_access(OP_WRITE, ADDR_DATA, 8'h3c, 1'b1, 8'h00);
        send_access(OP_WRITE, ADDR_STAT, 8'hf0, 1'b1, 8'h00);
        send_access(OP_WRITE, ADDR_CTL, 8'ha0, 1'b1, 8'h00);
        send_access(OP_WRITE, ADDR_STAT, 8'hb0, 1'b1, 8'h00);
        send_access(OP_WRITE, ADDR_CTL, 8'h20, 1'b1, 8'h5a);
        send_access(OP_WRITE, ADDR_CTL, 8'h00, 1'b1, 8'hc3);
        send_access(OP_WRITE, ADDR_STAT, 8'h90, 1'b1, 8'h00);
        send_access(OP_WRITE, ADDR_CTL, 8'h80, 1'b1, 8'h00);
        send_access(OP_READ, ADDR_DATA, 8'h00, 1'b0, 8'h00);
        wait_drained();
    endtask

    task automatic run_transfer();
        logic       tx;
        logic [7:0] ctl;
        logic [4:0] addr;
        int         steps;
        tx = 1'($urandom_range(1));
        ctl = 8'($urandom);
        ctl[CTL_PEND] = 1'b0;
        send_access(OP_WRITE, ADDR_DATA, 8'($urandom), 1'b1, 8'($urandom));
        send_access(OP_WRITE, ADDR_CTL, ctl, 1'($urandom_range(3) != 0), 8'($urandom));
        send_access(OP_WRITE, ADDR_STAT, {1'b1, tx, 2'b11, 4'($urandom)},
                    1'($urandom_range(3) != 0), 8'($urandom));
        steps = $urandom_range(1, 5);
        repeat (steps) begin
            if (tx && $urandom_range(1))
                send_access(OP_WRITE, ADDR_DATA, 8'($urandom), 1'b1, 8'($urandom));
            if ($urandom_range(3) == 0) begin
                addr = 5'($urandom_range(3) * 4);
                send_access(OP_READ, addr, 8'($urandom), 1'($urandom_range(1)), 8'($urandom));
            end
            ctl = 8'($urandom);
            ctl[CTL_PEND] = ($urandom_range(7) == 0);
            send_access(OP_WRITE, ADDR_CTL, ctl, 1'($urandom_range(3) != 0), 8'($urandom));
        end
        // now and then leave the transfer hanging
        if ($urandom_range(5) != 0) begin
            send_access(OP_WRITE, ADDR_STAT, {1'b1, tx, 2'b01, 4'($urandom)},
                        1'($urandom_range(1)), 8'($urandom));
            ctl = 8'($urandom);
            ctl[CTL_PEND] = 1'b0;
            send_access(OP_WRITE, ADDR_CTL, ctl, 1'($urandom_range(1)), 8'($urandom));
        end
    endtask

    task automatic test_random_transfers(input int idle_pct, input int stall_pct, input int count);
        int         target;
        logic [4:0] addr;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = accesses_sent + count;
        while (accesses_sent < target) begin
            if ($urandom_range(4) == 0) begin
                addr = $urandom_range(1) ? 5'($urandom_range(3) * 4) : 5'($urandom_range(31));
                send_access(1'($urandom_range(1)), addr, 8'($urandom),
                            1'($urandom_range(3) != 0), 8'($urandom));
            end else begin
                run_transfer();
            end
        end
        wait_drained();
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (access_results_q.size() == 0) begin
                report_mismatch("unexpected transaction", read_data, 8'h00);
            end else begin
                want = access_results_q.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (bus_action !== want.bus_action)
                    report_mismatch("bus_action", 8'(bus_action), 8'(want.bus_action));
                if (bus_byte !== want.bus_byte)
                    report_mismatch("bus_byte", bus_byte, want.bus_byte);
                if (bus_read_dir !== want.bus_read_dir)
                    report_mismatch("bus_read_dir", 8'(bus_read_dir), 8'(want.bus_read_dir));
                if (bus_nack_out !== want.bus_nack_out)
                    report_mismatch("bus_nack_out", 8'(bus_nack_out), 8'(want.bus_nack_out));
                if (irq_raise !== want.irq_raise)
                    report_mismatch("irq_raise", 8'(irq_raise), 8'(want.irq_raise));
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_master_transfer();
        test_random_transfers(0, 0, 300);
        test_random_transfers(63, 0, 300);
        test_random_transfers(0, 63, 300);
        test_random_transfers(31, 31, 300);
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
